// ===== sv/quad_motor_mix_crc_framer_assert.svh =====
// assertion helpers shared by the framer modules
// both expect signals named clock and reset in the calling scope
`ifndef QUAD_MOTOR_MIX_CRC_FRAMER_ASSERT_SVH
`define QUAD_MOTOR_MIX_CRC_FRAMER_ASSERT_SVH

// same-cycle implication
`define QMMCF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qmmcf: same-cycle check failed");

// next-cycle implication
`define QMMCF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qmmcf: next-cycle check failed");

`endif

// ===== sv/qmmcf_pkg.sv =====
package qmmcf_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int MOTORS      = 4;
   localparam int FRAME_LEN   = 15;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int BYTE_IDX_W  = $clog2(FRAME_LEN);

   localparam logic [7:0] DATA_LEN = 8'd8;
   localparam logic [BYTE_IDX_W-1:0] CRC_SPAN   = BYTE_IDX_W'(11);
   localparam logic [BYTE_IDX_W-1:0] FRAME_LAST = BYTE_IDX_W'(FRAME_LEN - 1);

   localparam int SPEED_W = 12;
   localparam int CORR_W  = 13;
   localparam int SUM_W   = 16;
   localparam int PWM_W   = 16;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 16;

   // input item kinds
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // configuration register indexes
   localparam logic [CSR_AW-1:0] REG_SPEED_MAX     = 3'd0;
   localparam logic [CSR_AW-1:0] REG_SPEED_MIN     = 3'd1;
   localparam logic [CSR_AW-1:0] REG_PROTECT_SPEED = 3'd2;
   localparam logic [CSR_AW-1:0] REG_PWM_BASE      = 3'd3;
   localparam logic [CSR_AW-1:0] REG_MIX_MODE      = 3'd4;
   localparam logic [CSR_AW-1:0] REG_HEAD_BYTES    = 3'd5;
   localparam logic [CSR_AW-1:0] REG_END_BYTES     = 3'd6;

   localparam logic [SPEED_W-1:0] SPEED_MAX_RST     = 12'd1000;
   localparam logic [SPEED_W-1:0] SPEED_MIN_RST     = 12'd0;
   localparam logic [SPEED_W-1:0] PROTECT_SPEED_RST = 12'd50;
   localparam logic [SPEED_W-1:0] PWM_BASE_RST      = 12'd1000;
   localparam logic               MIX_MODE_RST      = 1'b1;
   localparam logic [15:0]        HEAD_BYTES_RST    = 16'h0000;
   localparam logic [15:0]        END_BYTES_RST     = 16'h0000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_CLAMP,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic capture;
      logic sum;
      logic clamp;
      logic run;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic byte_avail;
      logic last;
   } sts_type;

endpackage

// ===== sv/qmmcf_ctrl.sv =====
module qmmcf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_func,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   input  qmmcf_pkg::sts_type  sts,
   output qmmcf_pkg::cmd_type  cmd
);

`include "quad_motor_mix_crc_framer_assert.svh"

   qmmcf_pkg::state_type state_ff;
   qmmcf_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qmmcf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qmmcf_pkg::ST_IDLE: begin
            if (req_valid && req_func == qmmcf_pkg::FUNC_TICK) state_in = qmmcf_pkg::ST_SUM;
         end
         qmmcf_pkg::ST_SUM: begin
            state_in = qmmcf_pkg::ST_CLAMP;
         end
         qmmcf_pkg::ST_CLAMP: begin
            state_in = qmmcf_pkg::ST_RUN;
         end
         qmmcf_pkg::ST_RUN: begin
            if (rsp_ready && sts.byte_avail && sts.last) state_in = qmmcf_pkg::ST_IDLE;
         end
         default: begin
            state_in = qmmcf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == qmmcf_pkg::ST_IDLE);
      rsp_valid   = (state_ff == qmmcf_pkg::ST_RUN) && sts.byte_avail;
      cmd.load    = req_valid && req_ready && (req_func == qmmcf_pkg::FUNC_LOAD);
      cmd.capture = req_valid && req_ready && (req_func == qmmcf_pkg::FUNC_TICK);
      cmd.sum     = (state_ff == qmmcf_pkg::ST_SUM);
      cmd.clamp   = (state_ff == qmmcf_pkg::ST_CLAMP);
      cmd.run     = (state_ff == qmmcf_pkg::ST_RUN);
      cmd.emit    = rsp_valid && rsp_ready;
   end

   `QMMCF_ASSERT_NEXT(a_tick_starts_mix, cmd.capture, state_ff == qmmcf_pkg::ST_SUM)
   `QMMCF_ASSERT_NEXT(a_load_stays_idle, cmd.load, state_ff == qmmcf_pkg::ST_IDLE)
   `QMMCF_ASSERT_IMPL(a_no_accept_while_sending, rsp_valid, !req_ready)

endmodule

// ===== sv/qmmcf_dpath.sv =====
module qmmcf_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  qmmcf_pkg::cmd_type                  cmd,
   output qmmcf_pkg::sts_type                  sts,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qmmcf_pkg::CSR_AW-1:0]        csr_index,
   input  logic [qmmcf_pkg::CSR_DW-1:0]        csr_wdata,
   input  logic [qmmcf_pkg::TABLE_AW-1:0]      req_table_index,
   input  logic [15:0]                         req_table_word,
   input  logic signed [qmmcf_pkg::CORR_W-1:0] req_throttle,
   input  logic signed [qmmcf_pkg::CORR_W-1:0] req_roll_corr,
   input  logic signed [qmmcf_pkg::CORR_W-1:0] req_pitch_corr,
   input  logic signed [qmmcf_pkg::CORR_W-1:0] req_yaw_corr,
   input  logic                                req_locked,
   output logic [7:0]                          rsp_frame_byte,
   output logic                                rsp_last_byte
);

`include "quad_motor_mix_crc_framer_assert.svh"

   localparam int SW = qmmcf_pkg::SPEED_W;
   localparam int CW = qmmcf_pkg::CORR_W;
   localparam int UW = qmmcf_pkg::SUM_W;
   localparam int PW = qmmcf_pkg::PWM_W;
   localparam int BW = qmmcf_pkg::BYTE_IDX_W;
   localparam int NM = qmmcf_pkg::MOTORS;

   // configuration registers
   logic [SW-1:0] speed_max_ff;
   logic [SW-1:0] speed_min_ff;
   logic [SW-1:0] protect_speed_ff;
   logic [SW-1:0] pwm_base_ff;
   logic          mix_mode_ff;
   logic [15:0]   head_bytes_ff;
   logic [15:0]   end_bytes_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_max_ff     <= qmmcf_pkg::SPEED_MAX_RST;
         speed_min_ff     <= qmmcf_pkg::SPEED_MIN_RST;
         protect_speed_ff <= qmmcf_pkg::PROTECT_SPEED_RST;
         pwm_base_ff      <= qmmcf_pkg::PWM_BASE_RST;
         mix_mode_ff      <= qmmcf_pkg::MIX_MODE_RST;
         head_bytes_ff    <= qmmcf_pkg::HEAD_BYTES_RST;
         end_bytes_ff     <= qmmcf_pkg::END_BYTES_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            qmmcf_pkg::REG_SPEED_MAX:     speed_max_ff     <= csr_wdata[SW-1:0];
            qmmcf_pkg::REG_SPEED_MIN:     speed_min_ff     <= csr_wdata[SW-1:0];
            qmmcf_pkg::REG_PROTECT_SPEED: protect_speed_ff <= csr_wdata[SW-1:0];
            qmmcf_pkg::REG_PWM_BASE:      pwm_base_ff      <= csr_wdata[SW-1:0];
            qmmcf_pkg::REG_MIX_MODE:      mix_mode_ff      <= csr_wdata[0];
            qmmcf_pkg::REG_HEAD_BYTES:    head_bytes_ff    <= csr_wdata[15:0];
            qmmcf_pkg::REG_END_BYTES:     end_bytes_ff     <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // upper clamp first, then lower, so inverted limits give speed_min
   function automatic logic [SW-1:0] clamp_speed(input logic signed [UW-1:0] v,
                                                 input logic [SW-1:0] hi,
                                                 input logic [SW-1:0] lo);
      logic signed [UW-1:0] r;
      r = v;
      if (r > $signed({{(UW-SW){1'b0}}, hi})) r = $signed({{(UW-SW){1'b0}}, hi});
      if (r < $signed({{(UW-SW){1'b0}}, lo})) r = $signed({{(UW-SW){1'b0}}, lo});
      return r[SW-1:0];
   endfunction

   // capture stage: throttle clamp, stop decision, corrections (halved in cross layout)
   logic [SW-1:0]        thr_clamped;
   logic signed [CW-1:0] half_roll;
   logic signed [CW-1:0] half_pitch;
   logic signed [CW-1:0] roll_adj;
   logic signed [CW-1:0] pitch_adj;

   logic [SW-1:0]        v_ff;
   logic                 stop_ff;
   logic signed [CW-1:0] a_ff;
   logic signed [CW-1:0] b_ff;
   logic signed [CW-1:0] ca_ff;
   logic signed [CW-1:0] cb_ff;
   logic signed [CW-1:0] z_ff;

   always_comb begin
      thr_clamped = clamp_speed(UW'(req_throttle), speed_max_ff, speed_min_ff);
      // truncate toward zero: bias negatives by one before the shift
      roll_adj    = req_roll_corr + $signed({{(CW-1){1'b0}}, req_roll_corr[CW-1]});
      pitch_adj   = req_pitch_corr + $signed({{(CW-1){1'b0}}, req_pitch_corr[CW-1]});
      half_roll   = roll_adj >>> 1;
      half_pitch  = pitch_adj >>> 1;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         v_ff    <= thr_clamped;
         stop_ff <= req_locked || (thr_clamped < protect_speed_ff);
         a_ff    <= mix_mode_ff ? half_roll : req_roll_corr;
         b_ff    <= mix_mode_ff ? half_pitch : req_pitch_corr;
         ca_ff   <= mix_mode_ff ? half_roll : '0;
         cb_ff   <= mix_mode_ff ? half_pitch : '0;
         z_ff    <= req_yaw_corr;
      end
   end

   // sum stage: cross layout adds the second axis to every motor
   logic signed [UW-1:0] sp_ff [NM];
   logic signed [UW-1:0] v_s;
   logic signed [UW-1:0] a_s;
   logic signed [UW-1:0] b_s;
   logic signed [UW-1:0] ca_s;
   logic signed [UW-1:0] cb_s;
   logic signed [UW-1:0] z_s;

   always_comb begin
      v_s  = $signed({{(UW-SW){1'b0}}, v_ff});
      a_s  = UW'(a_ff);
      b_s  = UW'(b_ff);
      ca_s = UW'(ca_ff);
      cb_s = UW'(cb_ff);
      z_s  = UW'(z_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         sp_ff[0] <= v_s + a_s - cb_s - z_s;
         sp_ff[1] <= v_s + ca_s + b_s + z_s;
         sp_ff[2] <= v_s - a_s + cb_s - z_s;
         sp_ff[3] <= v_s - ca_s - b_s + z_s;
      end
   end

   // clamp stage: pwm words in frame order 3,2,0,1
   logic [PW-1:0] pwm_ff [NM];
   logic [PW-1:0] base_w;

   assign base_w = {{(PW-SW){1'b0}}, pwm_base_ff};

   always_ff @(posedge clock) begin
      if (cmd.clamp) begin
         if (stop_ff) begin
            for (int i = 0; i < NM; i++) pwm_ff[i] <= base_w;
         end else begin
            pwm_ff[0] <= {{(PW-SW){1'b0}}, clamp_speed(sp_ff[3], speed_max_ff, speed_min_ff)}
                         + base_w;
            pwm_ff[1] <= {{(PW-SW){1'b0}}, clamp_speed(sp_ff[2], speed_max_ff, speed_min_ff)}
                         + base_w;
            pwm_ff[2] <= {{(PW-SW){1'b0}}, clamp_speed(sp_ff[0], speed_max_ff, speed_min_ff)}
                         + base_w;
            pwm_ff[3] <= {{(PW-SW){1'b0}}, clamp_speed(sp_ff[1], speed_max_ff, speed_min_ff)}
                         + base_w;
         end
      end
   end

   // frame assembly
   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [qmmcf_pkg::FRAME_LEN-1:0][7:0] frame;

   always_comb begin
      frame[0] = head_bytes_ff[15:8];
      frame[1] = head_bytes_ff[7:0];
      frame[2] = qmmcf_pkg::DATA_LEN;
      for (int i = 0; i < NM; i++) begin
         frame[3 + 2 * i] = pwm_ff[i][7:0];
         frame[4 + 2 * i] = pwm_ff[i][15:8];
      end
      frame[11] = crc_ff[15:8];
      frame[12] = crc_ff[7:0];
      frame[13] = end_bytes_ff[15:8];
      frame[14] = end_bytes_ff[7:0];
   end

   // crc table ram, one write port and one registered read port
   logic [15:0] crc_table_mem [qmmcf_pkg::TABLE_DEPTH];
   logic [15:0] rd_data_ff;
   logic [qmmcf_pkg::TABLE_AW-1:0] rd_addr;
   logic        rd_en;

   always_ff @(posedge clock) begin
      if (cmd.load) crc_table_mem[req_table_index] <= req_table_word;
      if (rd_en) rd_data_ff <= crc_table_mem[rd_addr];
   end

   // crc walker: address phase then data phase for each byte
   logic [BW-1:0] crc_cnt_ff;
   logic [BW-1:0] crc_cnt_in;
   logic          crc_phase_ff;
   logic          crc_phase_in;
   logic          crc_done;
   logic [BW-1:0] out_idx_ff;
   logic [BW-1:0] out_idx_in;

   always_comb begin
      crc_done     = (crc_cnt_ff == qmmcf_pkg::CRC_SPAN);
      rd_addr      = crc_ff[15:8] ^ frame[crc_cnt_ff];
      rd_en        = cmd.run && !crc_done && !crc_phase_ff;
      crc_in       = crc_ff;
      crc_cnt_in   = crc_cnt_ff;
      crc_phase_in = crc_phase_ff;
      out_idx_in   = out_idx_ff;
      if (cmd.capture) begin
         crc_in       = '0;
         crc_cnt_in   = '0;
         crc_phase_in = 1'b0;
         out_idx_in   = '0;
      end else begin
         if (cmd.run && !crc_done) begin
            crc_phase_in = !crc_phase_ff;
            if (crc_phase_ff) begin
               crc_in     = rd_data_ff ^ {crc_ff[7:0], 8'h00};
               crc_cnt_in = crc_cnt_ff + BW'(1);
            end
         end
         if (cmd.emit) out_idx_in = out_idx_ff + BW'(1);
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (reset) begin
         crc_cnt_ff   <= '0;
         crc_phase_ff <= 1'b0;
         out_idx_ff   <= '0;
      end else begin
         crc_cnt_ff   <= crc_cnt_in;
         crc_phase_ff <= crc_phase_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   // bytes ahead of the crc field go out while the crc is still running
   always_comb begin
      sts.byte_avail = (out_idx_ff < qmmcf_pkg::CRC_SPAN) || crc_done;
      sts.last       = (out_idx_ff == qmmcf_pkg::FRAME_LAST);
      rsp_frame_byte = frame[out_idx_ff];
      rsp_last_byte  = sts.last;
   end

   `QMMCF_ASSERT_IMPL(a_crc_ready_before_crc_bytes, cmd.emit && !(out_idx_ff < qmmcf_pkg::CRC_SPAN), crc_done)
   `QMMCF_ASSERT_NEXT(a_tick_clears_walker, cmd.capture, crc_cnt_ff == '0 && out_idx_ff == '0 && crc_ff == '0)
   `QMMCF_ASSERT_IMPL(a_crc_count_bounded, 1'b1, crc_cnt_ff <= qmmcf_pkg::CRC_SPAN)

endmodule

// ===== sv/quad_motor_mix_crc_framer.sv =====
// Quad motor mixer and framer. A load item (func 0) writes one word of the 256-entry
// CRC table and gives no result; the table must be loaded before ticks are sent. A
// tick item (func 1) clamps the throttle, mixes it with the roll, pitch and yaw
// corrections in plus or cross layout (or forces every motor to the base PWM when
// locked or below the protect speed) and emits a 15-byte frame, one byte per
// transfer, with rsp_last_byte marking the final byte. A tick holds the block from
// its acceptance until the last byte of its frame is taken; no new item is accepted
// before then. The mix passes through the capture, sum and clamp registers, then the
// CRC walks its eleven bytes, each with an address and a data phase through the
// table RAM's registered read port; the CRC bytes leave only after the walk, while
// the first eleven bytes stream out as it runs. Configuration writes are accepted
// in every cycle and must only be issued while no frame is pending.
module quad_motor_mix_crc_framer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qmmcf_pkg::CSR_AW-1:0]        csr_index,
   input  logic [qmmcf_pkg::CSR_DW-1:0]        csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [qmmcf_pkg::TABLE_AW-1:0]      req_table_index,
   input  logic [15:0]                         req_table_word,
   input  logic signed [qmmcf_pkg::CORR_W-1:0] req_throttle,
   input  logic signed [qmmcf_pkg::CORR_W-1:0] req_roll_corr,
   input  logic signed [qmmcf_pkg::CORR_W-1:0] req_pitch_corr,
   input  logic signed [qmmcf_pkg::CORR_W-1:0] req_yaw_corr,
   input  logic                                req_locked,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_frame_byte,
   output logic                                rsp_last_byte
);

   qmmcf_pkg::cmd_type cmd;
   qmmcf_pkg::sts_type sts;

   qmmcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   qmmcf_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_table_index (req_table_index),
      .req_table_word  (req_table_word),
      .req_throttle    (req_throttle),
      .req_roll_corr   (req_roll_corr),
      .req_pitch_corr  (req_pitch_corr),
      .req_yaw_corr    (req_yaw_corr),
      .req_locked      (req_locked),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule

// ===== bench/quad_motor_mix_crc_framer_test.sv =====
module quad_motor_mix_crc_framer_test;

   localparam int RANDOM_PER_PHASE = 30;
   localparam int PHASES           = 6;
   localparam int SETTLE_CYCLES    = 40;
   localparam int LONG_HOLD        = 400;
   localparam int RUN_LIMIT        = 1500000;
   localparam int N_DIRECTED       = 21;

   localparam int AW = qmmcf_pkg::TABLE_AW;
   localparam int CW = qmmcf_pkg::CORR_W;
   localparam int SW = qmmcf_pkg::SPEED_W;
   localparam int PW = qmmcf_pkg::PWM_W;
   localparam int NM = qmmcf_pkg::MOTORS;

   localparam logic FUNC_LOAD = qmmcf_pkg::FUNC_LOAD;
   localparam logic FUNC_TICK = qmmcf_pkg::FUNC_TICK;

   localparam logic                          MIX_PLUS     = 1'b0;
   localparam logic                          MIX_CROSS    = 1'b1;
   localparam logic [qmmcf_pkg::CSR_AW-1:0]  REG_UNMAPPED = 3'd7;

   typedef struct packed {
      logic                 func;
      logic [AW-1:0]        tindex;
      logic [15:0]          tword;
      logic signed [CW-1:0] thr;
      logic signed [CW-1:0] roll;
      logic signed [CW-1:0] pitch;
      logic signed [CW-1:0] yaw;
      logic                 locked;
   } motor_item_type;

   typedef logic [0:NM-1][PW-1:0] pwm_set_type;

   typedef struct packed {
      logic [2:0]     phase;
      motor_item_type it;
      logic           typed;
      pwm_set_type    pwm;
   } directed_row_type;

   typedef struct packed {
      logic [SW-1:0] smax;
      logic [SW-1:0] smin;
      logic [SW-1:0] prot;
      logic [SW-1:0] base;
      logic          mix;
      logic [15:0]   head;
      logic [15:0]   tail;
   } motor_cfg_type;

   typedef struct packed {
      logic [7:0] fbyte;
      logic       last;
   } frame_byte_type;

   // pwm words given in motor slot order 0..3 (slot 0 carries motor 3)
   localparam directed_row_type DIRECTED [N_DIRECTED] = '{
      '{3'd0, '{FUNC_LOAD, 8'hFF, 16'hFFFF, 13'sd4095, -13'sd4096, 13'sd4095, -13'sd4096, 1'b1},
         1'b0, '{16'd0, 16'd0, 16'd0, 16'd0}},
      '{3'd0, '{FUNC_LOAD, 8'h00, 16'h0000, -13'sd4096, 13'sd4095, -13'sd4096, 13'sd4095, 1'b0},
         1'b0, '{16'd0, 16'd0, 16'd0, 16'd0}},
      '{3'd0, '{FUNC_TICK, 8'hA5, 16'h5A5A, 13'sd4095, 13'sd100, -13'sd100, 13'sd7, 1'b1},
         1'b1, '{16'd1000, 16'd1000, 16'd1000, 16'd1000}},
      '{3'd0, '{FUNC_TICK, 8'h3C, 16'hFFFF, 13'sd49, 13'sd300, 13'sd300, 13'sd300, 1'b0},
         1'b1, '{16'd1000, 16'd1000, 16'd1000, 16'd1000}},
      '{3'd0, '{FUNC_TICK, 8'h00, 16'h0000, -13'sd4096, 13'sd0, 13'sd0, 13'sd0, 1'b0},
         1'b1, '{16'd1000, 16'd1000, 16'd1000, 16'd1000}},
      '{3'd0, '{FUNC_TICK, 8'h11, 16'h1234, 13'sd50, 13'sd0, 13'sd0, 13'sd0, 1'b0},
         1'b1, '{16'd1050, 16'd1050, 16'd1050, 16'd1050}},
      '{3'd0, '{FUNC_TICK, 8'h22, 16'h4321, 13'sd4095, 13'sd0, 13'sd0, 13'sd0, 1'b0},
         1'b1, '{16'd2000, 16'd2000, 16'd2000, 16'd2000}},
      // odd negative corrections halve toward zero
      '{3'd0, '{FUNC_TICK, 8'h33, 16'h0F0F, 13'sd500, -13'sd3, 13'sd0, 13'sd0, 1'b0},
         1'b1, '{16'd1501, 16'd1501, 16'd1499, 16'd1499}},
      '{3'd0, '{FUNC_TICK, 8'h44, 16'hF0F0, 13'sd500, 13'sd0, -13'sd3, 13'sd0, 1'b0},
         1'b1, '{16'd1501, 16'd1499, 16'd1501, 16'd1499}},
      '{3'd0, '{FUNC_TICK, 8'h55, 16'h8000, 13'sd500, 13'sd4095, -13'sd4096, 13'sd4095, 1'b0},
         1'b1, '{16'd2000, 16'd1000, 16'd1500, 16'd2000}},
      '{3'd0, '{FUNC_TICK, 8'h66, 16'h0001, 13'sd700, 13'sd123, -13'sd77, 13'sd31, 1'b0},
         1'b0, '{16'd0, 16'd0, 16'd0, 16'd0}},
      '{3'd1, '{FUNC_TICK, 8'h77, 16'h7FFF, 13'sd4095, 13'sd4095, -13'sd4096, 13'sd0, 1'b0},
         1'b1, '{16'd4095, 16'd0, 16'd4095, 16'd0}},
      '{3'd1, '{FUNC_TICK, 8'h88, 16'h8001, -13'sd1, 13'sd0, 13'sd0, 13'sd0, 1'b0},
         1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
      '{3'd1, '{FUNC_TICK, 8'h99, 16'h0002, 13'sd1000, 13'sd10, 13'sd20, 13'sd30, 1'b0},
         1'b1, '{16'd1010, 16'd960, 16'd980, 16'd1050}},
      '{3'd1, '{FUNC_TICK, 8'hAA, 16'h0003, 13'sd4095, 13'sd55, 13'sd66, 13'sd77, 1'b1},
         1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
      '{3'd1, '{FUNC_TICK, 8'hBB, 16'h0004, 13'sd2222, -13'sd999, 13'sd555, -13'sd4096, 1'b0},
         1'b0, '{16'd0, 16'd0, 16'd0, 16'd0}},
      // inverted clamps pin every unlocked speed to speed_min
      '{3'd2, '{FUNC_TICK, 8'hCC, 16'h0005, 13'sd50, 13'sd0, 13'sd0, 13'sd0, 1'b0},
         1'b1, '{16'd7095, 16'd7095, 16'd7095, 16'd7095}},
      '{3'd2, '{FUNC_TICK, 8'hDD, 16'h0006, -13'sd4096, 13'sd4095, 13'sd4095, -13'sd4096, 1'b0},
         1'b1, '{16'd7095, 16'd7095, 16'd7095, 16'd7095}},
      '{3'd2, '{FUNC_TICK, 8'hEE, 16'h0007, 13'sd4095, 13'sd0, 13'sd0, 13'sd0, 1'b1},
         1'b1, '{16'd4095, 16'd4095, 16'd4095, 16'd4095}},
      '{3'd3, '{FUNC_TICK, 8'h01, 16'h0008, 13'sd4095, -13'sd4096, 13'sd4095, 13'sd4095, 1'b0},
         1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
      '{3'd3, '{FUNC_TICK, 8'h02, 16'h0009, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 1'b1},
         1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}}
   };

   logic                           clock;
   logic                           reset;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [qmmcf_pkg::CSR_AW-1:0]   csr_index;
   logic [qmmcf_pkg::CSR_DW-1:0]   csr_wdata;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_func;
   logic [AW-1:0]                  req_table_index;
   logic [15:0]                    req_table_word;
   logic signed [CW-1:0]           req_throttle;
   logic signed [CW-1:0]           req_roll_corr;
   logic signed [CW-1:0]           req_pitch_corr;
   logic signed [CW-1:0]           req_yaw_corr;
   logic                           req_locked;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [7:0]                     rsp_frame_byte;
   logic                           rsp_last_byte;

   // predictor state
   motor_cfg_type  mix_cfg = '{qmmcf_pkg::SPEED_MAX_RST, qmmcf_pkg::SPEED_MIN_RST,
                               qmmcf_pkg::PROTECT_SPEED_RST, qmmcf_pkg::PWM_BASE_RST,
                               qmmcf_pkg::MIX_MODE_RST, qmmcf_pkg::HEAD_BYTES_RST,
                               qmmcf_pkg::END_BYTES_RST};
   logic [15:0]    crc_words [qmmcf_pkg::TABLE_DEPTH];
   frame_byte_type frame_bytes_due [$];

   logic        row_typed;
   pwm_set_type row_pwm;
   logic        no_idle;
   logic        rsp_long_hold;
   int          error_count;

   quad_motor_mix_crc_framer dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_table_index (req_table_index),
      .req_table_word  (req_table_word),
      .req_throttle    (req_throttle),
      .req_roll_corr   (req_roll_corr),
      .req_pitch_corr  (req_pitch_corr),
      .req_yaw_corr    (req_yaw_corr),
      .req_locked      (req_locked),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

   function automatic int clamp_speed_val(int v);
      if (v > int'(mix_cfg.smax)) v = int'(mix_cfg.smax);
      if (v < int'(mix_cfg.smin)) v = int'(mix_cfg.smin);
      return v;
   endfunction

   function automatic pwm_set_type motor_pwm(motor_item_type it);
      int          v, x, y, z, hx, hy;
      int          sp [NM];
      pwm_set_type pwm;
      v = clamp_speed_val(int'(it.thr));
      x = int'(it.roll);
      y = int'(it.pitch);
      z = int'(it.yaw);
      if (it.locked || v < int'(mix_cfg.prot)) begin
         for (int i = 0; i < NM; i++) pwm[i] = PW'(mix_cfg.base);
      end else begin
         if (mix_cfg.mix == MIX_PLUS) begin
            sp[0] = v + x - z;
            sp[1] = v + y + z;
            sp[2] = v - x - z;
            sp[3] = v - y + z;
         end else begin
            hx = x / 2;
            hy = y / 2;
            sp[0] = v + hx - hy - z;
            sp[1] = v + hx + hy + z;
            sp[2] = v - hx + hy - z;
            sp[3] = v - hx - hy + z;
         end
         for (int i = 0; i < NM; i++) sp[i] = clamp_speed_val(sp[i]);
         pwm[0] = PW'(sp[3] + int'(mix_cfg.base));
         pwm[1] = PW'(sp[2] + int'(mix_cfg.base));
         pwm[2] = PW'(sp[0] + int'(mix_cfg.base));
         pwm[3] = PW'(sp[1] + int'(mix_cfg.base));
      end
      return pwm;
   endfunction

   function automatic void queue_frame(pwm_set_type pwm);
      logic [7:0]  fr [qmmcf_pkg::FRAME_LEN];
      logic [15:0] crc;
      logic [7:0]  idx;
      fr[0] = mix_cfg.head[15:8];
      fr[1] = mix_cfg.head[7:0];
      fr[2] = qmmcf_pkg::DATA_LEN;
      for (int i = 0; i < NM; i++) begin
         fr[3 + 2 * i] = pwm[i][7:0];
         fr[4 + 2 * i] = pwm[i][15:8];
      end
      crc = '0;
      for (int i = 0; i < int'(qmmcf_pkg::CRC_SPAN); i++) begin
         idx = crc[15:8] ^ fr[i];
         crc = crc_words[idx] ^ {crc[7:0], 8'h00};
      end
      fr[11] = crc[15:8];
      fr[12] = crc[7:0];
      fr[13] = mix_cfg.tail[15:8];
      fr[14] = mix_cfg.tail[7:0];
      for (int i = 0; i < qmmcf_pkg::FRAME_LEN; i++)
         frame_bytes_due.push_back('{fr[i], (i == qmmcf_pkg::FRAME_LEN - 1)});
   endfunction

   function automatic int pick_gap();
      int r;
      r = int'($urandom_range(99));
      if (no_idle || r < 50) return 0;
      if (r < 88) return int'($urandom_range(3, 1));
      if (r < 97) return int'($urandom_range(10, 4));
      return int'($urandom_range(40, 20));
   endfunction

   function automatic logic signed [CW-1:0] random_corr();
      case ($urandom_range(5))
         0, 1: return CW'($urandom());
         2: return $urandom_range(1) ? 13'sd4095 : -13'sd4096;
         default: return CW'(int'($urandom_range(600)) - 300);
      endcase
   endfunction

   function automatic motor_item_type random_item();
      motor_item_type it;
      it.func   = ($urandom_range(3) == 0) ? FUNC_LOAD : FUNC_TICK;
      it.tindex = AW'($urandom());
      it.tword  = 16'($urandom());
      case ($urandom_range(5))
         0: it.thr = CW'($urandom());
         1: begin
            case ($urandom_range(3))
               0: it.thr = -13'sd4096;
               1: it.thr = 13'sd4095;
               2: it.thr = 13'sd0;
               default: it.thr = -13'sd1;
            endcase
         end
         // within two of the protect threshold
         2: it.thr = CW'(int'(mix_cfg.prot) + int'($urandom_range(4)) - 2);
         default: it.thr = CW'($urandom_range(1200));
      endcase
      it.roll   = random_corr();
      it.pitch  = random_corr();
      it.yaw    = random_corr();
      it.locked = ($urandom_range(7) == 0);
      return it;
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic offer(motor_item_type it, logic typed, pwm_set_type pwm);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func        <= it.func;
      req_table_index <= it.tindex;
      req_table_word  <= it.tword;
      req_throttle    <= it.thr;
      req_roll_corr   <= it.roll;
      req_pitch_corr  <= it.pitch;
      req_yaw_corr    <= it.yaw;
      req_locked      <= it.locked;
      row_typed       <= typed;
      row_pwm         <= pwm;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [qmmcf_pkg::CSR_AW-1:0] idx,
                            logic [qmmcf_pkg::CSR_DW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // unused upper data bits carry noise
   task automatic load_settings(motor_cfg_type c);
      write_reg(qmmcf_pkg::REG_SPEED_MAX, {4'($urandom()), c.smax});
      write_reg(qmmcf_pkg::REG_SPEED_MIN, {4'($urandom()), c.smin});
      write_reg(qmmcf_pkg::REG_PROTECT_SPEED, {4'($urandom()), c.prot});
      write_reg(qmmcf_pkg::REG_PWM_BASE, {4'($urandom()), c.base});
      write_reg(qmmcf_pkg::REG_MIX_MODE, {15'($urandom()), c.mix});
      write_reg(qmmcf_pkg::REG_HEAD_BYTES, c.head);
      write_reg(qmmcf_pkg::REG_END_BYTES, c.tail);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_frames_out();
      req_valid <= 1'b0;
      do @(negedge clock); while (frame_bytes_due.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("quad_motor_mix_crc_framer_test: done, errors");
      $finish;
   end

   // receiver side
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_long_hold) begin
            rsp_long_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      frame_byte_type due;
      motor_item_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_due.size() == 0) begin
               $error("frame_byte: no transfer expected, got %02h", rsp_frame_byte);
               error_count++;
            end else begin
               due = frame_bytes_due.pop_front();
               if (rsp_frame_byte !== due.fbyte) begin
                  $error("frame_byte: expected %02h, got %02h", due.fbyte, rsp_frame_byte);
                  error_count++;
               end
               if (rsp_last_byte !== due.last) begin
                  $error("last_byte: expected %0b, got %0b", due.last, rsp_last_byte);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               qmmcf_pkg::REG_SPEED_MAX:     mix_cfg.smax = csr_wdata[SW-1:0];
               qmmcf_pkg::REG_SPEED_MIN:     mix_cfg.smin = csr_wdata[SW-1:0];
               qmmcf_pkg::REG_PROTECT_SPEED: mix_cfg.prot = csr_wdata[SW-1:0];
               qmmcf_pkg::REG_PWM_BASE:      mix_cfg.base = csr_wdata[SW-1:0];
               qmmcf_pkg::REG_MIX_MODE:      mix_cfg.mix  = csr_wdata[0];
               qmmcf_pkg::REG_HEAD_BYTES:    mix_cfg.head = csr_wdata[15:0];
               qmmcf_pkg::REG_END_BYTES:     mix_cfg.tail = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            got = '{req_func, req_table_index, req_table_word, req_throttle, req_roll_corr,
                    req_pitch_corr, req_yaw_corr, req_locked};
            if (got.func == FUNC_LOAD) crc_words[got.tindex] = got.tword;
            else queue_frame(row_typed ? row_pwm : motor_pwm(got));
         end
      end
   end

   initial begin
      motor_cfg_type c;
      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_func        = FUNC_LOAD;
      req_table_index = '0;
      req_table_word  = '0;
      req_throttle    = '0;
      req_roll_corr   = '0;
      req_pitch_corr  = '0;
      req_yaw_corr    = '0;
      req_locked      = 1'b0;
      row_typed       = 1'b0;
      row_pwm         = '0;
      no_idle         = 1'b0;
      rsp_long_hold   = 1'b0;
      error_count     = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         no_idle = (p == 4);
         if (p == 0) begin
            // every table entry is written before the first tick reads it
            for (int i = 0; i < qmmcf_pkg::TABLE_DEPTH; i++)
               offer('{FUNC_LOAD, AW'(i), 16'($urandom()), CW'($urandom()),
                       CW'($urandom()), CW'($urandom()), CW'($urandom()),
                       1'($urandom())}, 1'b0, '0);
         end else begin
            wait_frames_out();
            repeat (SETTLE_CYCLES) @(negedge clock);
            case (p)
               1: c = '{12'd4095, 12'd0, 12'd0, 12'd0, MIX_PLUS, 16'hFFFF, 16'h0000};
               2: c = '{12'd100, 12'd3000, 12'd2000, 12'd4095, MIX_CROSS, 16'h55AA, 16'hFFFF};
               3: c = '{12'd0, 12'd0, 12'd0, 12'd0, MIX_PLUS, 16'h0000, 16'h0000};
               4: c = '{12'($urandom_range(4095, 1500)), 12'($urandom_range(400)),
                        12'($urandom_range(300)), 12'($urandom()), 1'($urandom()),
                        16'($urandom()), 16'($urandom())};
               default: begin
                  write_reg(REG_UNMAPPED, 16'($urandom()));
                  c = '{12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
                        1'($urandom()), 16'($urandom()), 16'($urandom())};
               end
            endcase
            load_settings(c);
         end

         for (int i = 0; i < N_DIRECTED; i++)
            if (int'(DIRECTED[i].phase) == p)
               offer(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].pwm);

         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            // stall the output long enough to back up the input
            if (p == 1 && k == 6) rsp_long_hold = 1'b1;
            if (k == RANDOM_PER_PHASE / 2) wait_frames_out();
            offer(random_item(), 1'b0, '0);
         end
      end

      wait_frames_out();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && frame_bytes_due.size() == 0)
         $display("quad_motor_mix_crc_framer_test: done, clean");
      else
         $display("quad_motor_mix_crc_framer_test: done, errors");
      $finish;
   end

endmodule
